// ===== design/tcg_pkg.sv =====
// Shared types, constants and helper functions for the teletext character generator.
// No dependencies; every other design file imports this package.
package tcg_pkg;

	localparam int ROW_COUNT   = 25;
	localparam int GLYPH_COUNT = 96;
	localparam int GLYPH_ROWS  = 10;
	localparam int FONT_DEPTH  = GLYPH_COUNT * GLYPH_ROWS;
	localparam int FONT_AW     = $clog2(FONT_DEPTH);
	localparam int FIFO_DEPTH  = 4;
	localparam int FIFO_AW     = $clog2(FIFO_DEPTH);

	typedef enum logic [2:0] {
		MODE_LOAD    = 3'd0,
		MODE_FRAME   = 3'd1,
		MODE_ROW     = 3'd2,
		MODE_LINE    = 3'd3,
		MODE_CHAR    = 3'd4,
		MODE_ROW_END = 3'd5,
		MODE_FLASH   = 3'd6
	} mode_t;

	localparam logic [6:0] CC_FLASH       = 7'h08;
	localparam logic [6:0] CC_STEADY      = 7'h09;
	localparam logic [6:0] CC_NORMAL_SIZE = 7'h0C;
	localparam logic [6:0] CC_DOUBLE      = 7'h0D;
	localparam logic [6:0] CC_CONCEAL     = 7'h18;
	localparam logic [6:0] CC_CONTIGUOUS  = 7'h19;
	localparam logic [6:0] CC_SEPARATED   = 7'h1A;
	localparam logic [6:0] CC_BLACK_BG    = 7'h1C;
	localparam logic [6:0] CC_NEW_BG      = 7'h1D;
	localparam logic [6:0] CC_HOLD        = 7'h1E;
	localparam logic [6:0] CC_RELEASE     = 7'h1F;

	localparam logic [6:0] CODE_SPACE     = 7'h20;
	localparam logic [6:0] CODE_UPPER_MOS = 7'h3F;
	localparam logic [6:0] CODE_LOWER_MOS = 7'h60;
	localparam logic [5:0] FLASH_ON_LIMIT = 6'd48;

	typedef struct packed {
		logic [2:0] fg;
		logic [2:0] bg;
		logic       mosaic;
		logic       sep;
		logic       flash;
		logic       hold;
		logic       dh;
	} attr_t;

	localparam attr_t ATTR_DEFAULT = '{fg: 3'd7, default: '0};

	typedef struct packed {
		logic                 we;
		logic [FONT_AW-1:0]   waddr;
		logic [5:0]           wdata;
		logic                 re;
		logic [FONT_AW-1:0]   raddr;
	} font_req_t;

	typedef struct packed {
		logic       use_font;
		logic [5:0] bits;
		logic [2:0] fg;
		logic [2:0] bg;
	} cell_t;

	function automatic logic [5:0] mosaic_row(input logic [6:0] code, input logic [3:0] la,
			input logic sep);
		logic [5:0] six;
		logic [6:0] diff;
		logic [1:0] pair;
		logic [5:0] m;
		diff = code - CODE_SPACE;
		six = (code >= CODE_LOWER_MOS) ? diff[5:0] : code[5:0];
		if (la <= 4'd2) begin
			pair = six[1:0];
		end else if (la <= 4'd6) begin
			pair = six[3:2];
		end else begin
			pair = six[5:4];
		end
		m = {{3{pair[1]}}, {3{pair[0]}}};
		if (sep) begin
			m = m & 6'b011011;
			if (la == 4'd2 || la == 4'd6 || la == 4'd9) begin
				m = '0;
			end
		end
		return m;
	endfunction

endpackage

// ===== design/tcg_font_mem.sv =====
// Font store: single-port-write, single-port-read synchronous RAM of glyph rows.
// Uses tcg_pkg for the request struct and depth; read data is registered.
module tcg_font_mem
	import tcg_pkg::*;
(
	input  logic      clk,
	input  font_req_t req,
	output logic [5:0] rdata
);

	logic [5:0] mem_q [FONT_DEPTH];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem_q[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rdata <= mem_q[req.raddr];
		end
	end

endmodule

// ===== design/tcg_ctrl.sv =====
// Event decoder and attribute state: control codes, line addressing, flash phase.
// Uses tcg_pkg; drives the font store request and the stage-one cell register.
module tcg_ctrl
	import tcg_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        accept,
	input  mode_t       mode,
	input  logic [7:0]  char_byte,
	input  logic [3:0]  line_number,
	input  logic [4:0]  row_number,
	input  logic [6:0]  glyph_index,
	input  logic [3:0]  glyph_row,
	input  logic [5:0]  glyph_bits,
	output font_req_t   font_req,
	output logic        valid_s1,
	output cell_t       cell_s1
);

	logic [5:0] flash_count_q, flash_count_n;
	logic       flash_visible_q, flash_visible_n;
	logic       dh_seen_q, dh_seen_n;
	logic       dh_prev_q, dh_prev_n;
	logic [3:0] line_q, line_n;
	attr_t      pend_q, pend_n;
	logic [6:0] held_code_q, held_code_n;
	logic       held_sep_q, held_sep_n;

	logic [6:0] code;
	logic       is_ctrl;
	logic       blank;
	logic [3:0] la;
	logic [3:0] la_low;
	logic [6:0] font_idx;
	logic [FONT_AW-1:0] load_addr;
	logic [FONT_AW-1:0] char_addr;
	cell_t      cell_n;

	always_comb begin
		code = char_byte[6:0];
		is_ctrl = code < CODE_SPACE;
		blank = dh_prev_q && !pend_q.dh;
		la_low = {1'b0, line_q[3:1]} + 4'd5;
		if (dh_prev_q) begin
			la = (la_low > 4'd9) ? 4'd9 : la_low;
		end else if (pend_q.dh) begin
			la = (line_q[3:1] > 3'd4) ? 4'd4 : {1'b0, line_q[3:1]};
		end else begin
			la = (line_q > 4'd9) ? 4'd9 : line_q;
		end
		font_idx = blank ? 7'd0 : (code - CODE_SPACE);
		load_addr = (FONT_AW'(glyph_index) << 3) + (FONT_AW'(glyph_index) << 1)
			+ FONT_AW'(glyph_row);
		char_addr = (FONT_AW'(font_idx) << 3) + (FONT_AW'(font_idx) << 1) + FONT_AW'(la);
	end

	always_comb begin
		flash_count_n = flash_count_q;
		flash_visible_n = flash_visible_q;
		dh_seen_n = dh_seen_q;
		dh_prev_n = dh_prev_q;
		line_n = line_q;
		pend_n = pend_q;
		held_code_n = held_code_q;
		held_sep_n = held_sep_q;
		font_req = '0;
		font_req.wdata = glyph_bits;
		font_req.waddr = load_addr;
		font_req.raddr = char_addr;
		cell_n = '0;
		cell_n.bg = pend_q.bg;
		cell_n.fg = (pend_q.flash && !flash_visible_q) ? pend_q.bg : pend_q.fg;
		if (accept) begin
			unique case (mode)
				MODE_LOAD: begin
					if (7'(glyph_index) < 7'(GLYPH_COUNT) && glyph_row < 4'(GLYPH_ROWS)) begin
						font_req.we = 1'b1;
					end
				end
				MODE_FRAME: begin
					dh_seen_n = 1'b0;
					dh_prev_n = 1'b0;
				end
				MODE_ROW: begin
					if (6'(row_number) < 6'(ROW_COUNT)) begin
						dh_seen_n = 1'b0;
					end
				end
				MODE_LINE: begin
					line_n = line_number;
					pend_n = ATTR_DEFAULT;
					held_code_n = CODE_SPACE;
					held_sep_n = 1'b0;
				end
				MODE_CHAR: begin
					if (is_ctrl) begin
						priority if (code[4:3] == 2'b00 && code[2:0] != 3'd0) begin
							pend_n.fg = code[2:0];
							pend_n.mosaic = 1'b0;
							held_code_n = CODE_SPACE;
						end else if (code[4:3] == 2'b10 && code[2:0] != 3'd0) begin
							pend_n.fg = code[2:0];
							pend_n.mosaic = 1'b1;
						end else begin
							unique case (code)
								CC_FLASH:       pend_n.flash = 1'b1;
								CC_STEADY:      pend_n.flash = 1'b0;
								CC_NORMAL_SIZE: pend_n.dh = 1'b0;
								CC_DOUBLE: begin
									pend_n.dh = 1'b1;
									dh_seen_n = 1'b1;
								end
								CC_CONCEAL:     pend_n.fg = pend_q.bg;
								CC_CONTIGUOUS:  pend_n.sep = 1'b0;
								CC_SEPARATED:   pend_n.sep = 1'b1;
								CC_BLACK_BG:    pend_n.bg = 3'd0;
								CC_NEW_BG:      pend_n.bg = pend_q.fg;
								CC_HOLD:        pend_n.hold = 1'b1;
								CC_RELEASE:     pend_n.hold = 1'b0;
								default: ;
							endcase
						end
						if (pend_q.hold && held_code_n != CODE_SPACE) begin
							cell_n.bits = mosaic_row(held_code_n, la, held_sep_n);
						end
					end else if (pend_q.mosaic && !blank
							&& (code <= CODE_UPPER_MOS || code >= CODE_LOWER_MOS)) begin
						cell_n.bits = mosaic_row(code, la, pend_q.sep);
						held_code_n = code;
						held_sep_n = pend_q.sep;
					end else begin
						cell_n.use_font = 1'b1;
						font_req.re = 1'b1;
					end
				end
				MODE_ROW_END: dh_prev_n = dh_seen_q;
				MODE_FLASH: begin
					flash_count_n = flash_count_q + 6'd1;
					flash_visible_n = flash_count_n < FLASH_ON_LIMIT;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flash_count_q <= '0;
			flash_visible_q <= 1'b0;
			dh_seen_q <= 1'b0;
			dh_prev_q <= 1'b0;
			line_q <= '0;
			pend_q <= ATTR_DEFAULT;
			held_code_q <= CODE_SPACE;
			held_sep_q <= 1'b0;
			valid_s1 <= 1'b0;
		end else begin
			flash_count_q <= flash_count_n;
			flash_visible_q <= flash_visible_n;
			dh_seen_q <= dh_seen_n;
			dh_prev_q <= dh_prev_n;
			line_q <= line_n;
			pend_q <= pend_n;
			held_code_q <= held_code_n;
			held_sep_q <= held_sep_n;
			valid_s1 <= accept && (mode == MODE_CHAR);
		end
	end

	always_ff @(posedge clk) begin
		cell_s1 <= cell_n;
	end

endmodule

// ===== design/tcg_out.sv =====
// Pixel coloring and output buffer: merges font data with the stage-one cell.
// Uses tcg_pkg; a small queue decouples the stream output from the pipeline.
module tcg_out
	import tcg_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        valid_s1,
	input  cell_t       cell_s1,
	input  logic [5:0]  font_rdata,
	output logic        room,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata
);

	logic [17:0]        fifo_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [FIFO_AW:0]   count_q;
	logic [5:0]         bits;
	logic [17:0]        pixels;
	logic               pop;

	always_comb begin
		bits = cell_s1.use_font ? font_rdata : cell_s1.bits;
		for (int i = 0; i < 6; i++) begin
			pixels[3*i +: 3] = bits[i] ? cell_s1.fg : cell_s1.bg;
		end
		pop = m_axis_tvalid && m_axis_tready;
		room = (count_q + (FIFO_AW+1)'(valid_s1)) < (FIFO_AW+1)'(FIFO_DEPTH);
		m_axis_tvalid = count_q != '0;
		m_axis_tdata = {6'd0, fifo_q[rd_ptr_q]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (valid_s1) begin
				wr_ptr_q <= wr_ptr_q + FIFO_AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
			end
			count_q <= count_q + (FIFO_AW+1)'(valid_s1) - (FIFO_AW+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			fifo_q[wr_ptr_q] <= pixels;
		end
	end

endmodule

// ===== design/teletext_character_generator.sv =====
// Top level of the teletext character generator.
// Instantiates tcg_ctrl, tcg_font_mem and tcg_out; uses tcg_pkg.
//
// Usage: each input beat carries one event, its kind in s_axis_tuser. Glyph-row
// loads fill the font store; frame, row and scanline events set up double-height
// addressing and line defaults; flash ticks advance the flash phase. Only a
// character event produces an output beat: six 3-bit pixel colors for one
// scanline of that cell.
// Path: an accepted character's cell is registered in the stage-one register while
// its font row is read, then written into the output queue that drives m_axis.
// Throughput: one event per cycle while s_axis_tready is high; the font store is
// read once per font-drawn character, through its single registered read port.
// Reset clears all attribute and double-height state and empties the output
// queue. The font store is not cleared and must be loaded before use.
// When the receiver stalls, results collect in a four-beat output queue;
// s_axis_tready drops once the queue and the pipeline stage together hold four beats.
module teletext_character_generator
	import tcg_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// char_byte[7:0], line_number[11:8], row_number[16:12], glyph_index[23:17],
	// glyph_row[27:24], glyph_bits[33:28], zero fill[39:34]
	input  logic [39:0] s_axis_tdata,
	// mode[2:0]
	input  logic [2:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// pixel_zero[2:0], pixel_one[5:3], pixel_two[8:6], pixel_three[11:9],
	// pixel_four[14:12], pixel_five[17:15], zero fill[23:18]
	output logic [23:0] m_axis_tdata
);

	logic       accept;
	font_req_t  font_req;
	logic [5:0] font_rdata;
	logic       valid_s1;
	cell_t      cell_s1;
	logic       room;

	assign accept = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = room;

	tcg_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.mode       (mode_t'(s_axis_tuser)),
		.char_byte  (s_axis_tdata[7:0]),
		.line_number(s_axis_tdata[11:8]),
		.row_number (s_axis_tdata[16:12]),
		.glyph_index(s_axis_tdata[23:17]),
		.glyph_row  (s_axis_tdata[27:24]),
		.glyph_bits (s_axis_tdata[33:28]),
		.font_req   (font_req),
		.valid_s1   (valid_s1),
		.cell_s1    (cell_s1)
	);

	tcg_font_mem u_font (
		.clk  (clk),
		.req  (font_req),
		.rdata(font_rdata)
	);

	tcg_out u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.valid_s1     (valid_s1),
		.cell_s1      (cell_s1),
		.font_rdata   (font_rdata),
		.room         (room),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

endmodule

// ===== design/tcg_checker.sv =====
// Port-level checker for the teletext character generator, bound to the top level.
// Uses tcg_pkg for the event kinds.
module tcg_checker
	import tcg_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [2:0]  s_axis_tuser,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [23:0] m_axis_tdata
);

	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("Stalled output beat changed.");

	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |->
			$past(s_axis_tvalid && s_axis_tready && s_axis_tuser == MODE_CHAR, 2))
		else $error("Output beat without a character accepted two cycles earlier.");

	assert property (@(posedge clk) !arst_n |=> !m_axis_tvalid)
		else $error("Output valid right after reset.");

	assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid)
		else $error("Input stalled while no output beat is pending.");

endmodule

bind teletext_character_generator tcg_checker u_tcg_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready),
	.s_axis_tuser (s_axis_tuser),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata)
);
